@@ src/mch_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mch_pkg;

	// CORDIC depth: default and the table length that bounds it
	localparam int unsigned ANGLE_ITER_DEFAULT = 16;
	localparam int unsigned ANGLE_ITER_MAX     = 24;

	localparam int unsigned RAW_W     = 16;
	localparam int unsigned OFF_W     = 17;
	localparam int unsigned SCALE_W   = 16;
	localparam int unsigned DIFF_W    = 18;
	localparam int unsigned PROD_W    = 34;
	localparam int unsigned VEC_W     = 53;
	localparam int unsigned ANG_W     = 32;
	localparam int unsigned HEAD_W    = 15;
	localparam int unsigned FRAC_BITS = 15;
	localparam int unsigned ANGLE_FRAC = 16;
	localparam int unsigned HEAD_WIDE_W = ANG_W - ANGLE_FRAC;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 17;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z  = 3'd5;

	localparam logic signed [OFF_W-1:0] OFFSET_X_RESET = -17'sd2120;
	localparam logic signed [OFF_W-1:0] OFFSET_Y_RESET = 17'sd401;
	localparam logic signed [OFF_W-1:0] OFFSET_Z_RESET = 17'sd3837;
	localparam logic [SCALE_W-1:0]      SCALE_X_RESET  = 16'd18956;
	localparam logic [SCALE_W-1:0]      SCALE_Y_RESET  = 16'd18292;
	localparam logic [SCALE_W-1:0]      SCALE_Z_RESET  = 16'd13213;

	// angles in units of 2^-22 degree
	localparam logic signed [ANG_W-1:0] HALF_TURN = 32'sd754974720;
	localparam logic signed [ANG_W-1:0] FULL_TURN = 32'sd1509949440;
	localparam logic [HEAD_WIDE_W-1:0]  HEADING_FULL = 16'd23040;

	typedef struct packed {
		logic signed [OFF_W-1:0] off_x;
		logic signed [OFF_W-1:0] off_y;
		logic signed [OFF_W-1:0] off_z;
		logic [SCALE_W-1:0]      scale_x;
		logic [SCALE_W-1:0]      scale_y;
		logic [SCALE_W-1:0]      scale_z;
	} cfg_t;

	// vector under rotation plus the calibrated axes riding alongside
	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
		logic                    zero;
		logic signed [RAW_W-1:0] cal_x;
		logic signed [RAW_W-1:0] cal_y;
		logic signed [RAW_W-1:0] cal_z;
	} vec_t;

	// atan(2^-idx), 2^-22 degree units
	function automatic logic signed [ANG_W-1:0] atan_angle(input int unsigned idx);
		logic signed [ANG_W-1:0] a;
		unique case (idx)
			0:  a = 32'sd188743680;
			1:  a = 32'sd111421900;
			2:  a = 32'sd58872272;
			3:  a = 32'sd29884485;
			4:  a = 32'sd15000234;
			5:  a = 32'sd7507429;
			6:  a = 32'sd3754631;
			7:  a = 32'sd1877430;
			8:  a = 32'sd938729;
			9:  a = 32'sd469366;
			10: a = 32'sd234683;
			11: a = 32'sd117342;
			12: a = 32'sd58671;
			13: a = 32'sd29335;
			14: a = 32'sd14668;
			15: a = 32'sd7334;
			16: a = 32'sd3667;
			17: a = 32'sd1833;
			18: a = 32'sd917;
			19: a = 32'sd458;
			20: a = 32'sd229;
			21: a = 32'sd115;
			22: a = 32'sd57;
			23: a = 32'sd29;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

@@ src/mch_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mch_cfg_regs import mch_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off_x   <= OFFSET_X_RESET;
			cfg_q.off_y   <= OFFSET_Y_RESET;
			cfg_q.off_z   <= OFFSET_Z_RESET;
			cfg_q.scale_x <= SCALE_X_RESET;
			cfg_q.scale_y <= SCALE_Y_RESET;
			cfg_q.scale_z <= SCALE_Z_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_OFFSET_X: cfg_q.off_x   <= cfg_data;
				REG_OFFSET_Y: cfg_q.off_y   <= cfg_data;
				REG_OFFSET_Z: cfg_q.off_z   <= cfg_data;
				REG_SCALE_X:  cfg_q.scale_x <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Y:  cfg_q.scale_y <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Z:  cfg_q.scale_z <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/mch_calib.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mch_calib import mch_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cfg_t                    cfg,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [RAW_W-1:0] raw_x,
	input  wire logic signed [RAW_W-1:0] raw_y,
	input  wire logic signed [RAW_W-1:0] raw_z,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output vec_t                         out_vec
);

	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [PROD_W-1:0] MAG_POS    = PROD_W'((1 << (RAW_W - 1)) - 1);
	localparam logic [PROD_W-1:0] MAG_NEG    = PROD_W'(1 << (RAW_W - 1));

	logic                     v_s1, v_s2, v_s3;
	logic                     ready_s1, ready_s2, ready_s3;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [PROD_W-1:0] px_s2, py_s2, pz_s2;
	vec_t                     vec_s3;
	vec_t                     vec_next;

	// round half away from zero, then clamp to 16 bits
	function automatic logic signed [RAW_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		logic [PROD_W-1:0] r_neg;
		logic signed [RAW_W-1:0] res;
		mag   = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		r     = (mag + ROUND_HALF) >> FRAC_BITS;
		r_neg = -r;
		if (!p[PROD_W-1]) begin
			res = (r > MAG_POS) ? RAW_W'(MAG_POS) : r[RAW_W-1:0];
		end else begin
			res = (r > MAG_NEG) ? RAW_W'(MAG_NEG) : r_neg[RAW_W-1:0];
		end
		return res;
	endfunction

	assign ready_s1 = !v_s1 || ready_s2;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s3 = !v_s3 || out_ready;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= in_valid;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
		end
	end

	// pre-rotation into the right half plane, zero vector flagged
	always_comb begin
		logic signed [VEC_W-1:0] x0;
		logic signed [VEC_W-1:0] y0;
		x0 = VEC_W'(px_s2) <<< ANGLE_FRAC;
		y0 = VEC_W'(py_s2) <<< ANGLE_FRAC;
		vec_next.zero  = (px_s2 == '0) && (py_s2 == '0);
		vec_next.cal_x = round_sat(px_s2);
		vec_next.cal_y = round_sat(py_s2);
		vec_next.cal_z = round_sat(pz_s2);
		if (px_s2[PROD_W-1]) begin
			vec_next.x = -x0;
			vec_next.y = -y0;
			vec_next.z = HALF_TURN;
		end else begin
			vec_next.x = x0;
			vec_next.y = y0;
			vec_next.z = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			dx_s1 <= (DIFF_W'(raw_x) <<< 1) - DIFF_W'($signed(cfg.off_x));
			dy_s1 <= (DIFF_W'(raw_y) <<< 1) - DIFF_W'($signed(cfg.off_y));
			dz_s1 <= (DIFF_W'(raw_z) <<< 1) - DIFF_W'($signed(cfg.off_z));
		end
		if (ready_s2 && v_s1) begin
			px_s2 <= PROD_W'(dx_s1) * PROD_W'($signed({1'b0, cfg.scale_x}));
			py_s2 <= PROD_W'(dy_s1) * PROD_W'($signed({1'b0, cfg.scale_y}));
			pz_s2 <= PROD_W'(dz_s1) * PROD_W'($signed({1'b0, cfg.scale_z}));
		end
		if (ready_s3 && v_s2) begin
			vec_s3 <= vec_next;
		end
	end

	assign out_valid = v_s3;
	assign out_vec   = vec_s3;

endmodule

`default_nettype wire

@@ src/mch_cordic_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mch_cordic_stage import mch_pkg::*; #(
	parameter int unsigned STAGE_IDX = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire vec_t in_vec,
	output logic      out_valid,
	input  wire logic out_ready,
	output vec_t      out_vec
);

	localparam logic signed [ANG_W-1:0] STEP_ANGLE = atan_angle(STAGE_IDX);

	logic v_s1;
	vec_t vec_s1;
	vec_t vec_next;

	assign in_ready = !v_s1 || out_ready;

	// one micro-rotation towards y = 0; arithmetic shift is a floor shift
	always_comb begin
		logic signed [VEC_W-1:0] sx;
		logic signed [VEC_W-1:0] sy;
		sx       = $signed(in_vec.x) >>> STAGE_IDX;
		sy       = $signed(in_vec.y) >>> STAGE_IDX;
		vec_next = in_vec;
		if (!in_vec.y[VEC_W-1]) begin
			vec_next.x = $signed(in_vec.x) + sy;
			vec_next.y = $signed(in_vec.y) - sx;
			vec_next.z = $signed(in_vec.z) + STEP_ANGLE;
		end else begin
			vec_next.x = $signed(in_vec.x) - sy;
			vec_next.y = $signed(in_vec.y) + sx;
			vec_next.z = $signed(in_vec.z) - STEP_ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_s1 <= vec_next;
		end
	end

	assign out_valid = v_s1;
	assign out_vec   = vec_s1;

endmodule

`default_nettype wire

@@ src/mch_heading.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mch_heading import mch_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire vec_t               in_vec,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [RAW_W-1:0] cal_x,
	output logic signed [RAW_W-1:0] cal_y,
	output logic signed [RAW_W-1:0] cal_z,
	output logic [HEAD_W-1:0]       heading
);

	localparam logic signed [ANG_W-1:0] HEAD_ROUND = ANG_W'(1) << (ANGLE_FRAC - 1);

	logic                     v_s1;
	logic signed [RAW_W-1:0]  cal_x_s1, cal_y_s1, cal_z_s1;
	logic [HEAD_W-1:0]        heading_s1;
	logic [HEAD_W-1:0]        heading_next;

	assign in_ready = !v_s1 || out_ready;

	// wrap into one turn, round to 1/64 degree, fold a full turn back to zero; a zero vector gives 0
	always_comb begin
		logic signed [ANG_W-1:0]  z_wrap;
		logic signed [ANG_W-1:0]  z_round;
		logic [HEAD_WIDE_W-1:0]   h_wide;
		logic [HEAD_WIDE_W-1:0]   h_fold;
		z_wrap  = in_vec.z[ANG_W-1] ? ($signed(in_vec.z) + FULL_TURN) : $signed(in_vec.z);
		z_round = z_wrap + HEAD_ROUND;
		h_wide  = z_round[ANG_W-1:ANGLE_FRAC];
		h_fold  = (h_wide >= HEADING_FULL) ? (h_wide - HEADING_FULL) : h_wide;
		heading_next = in_vec.zero ? '0 : h_fold[HEAD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cal_x_s1   <= in_vec.cal_x;
			cal_y_s1   <= in_vec.cal_y;
			cal_z_s1   <= in_vec.cal_z;
			heading_s1 <= heading_next;
		end
	end

	assign out_valid = v_s1;
	assign cal_x     = cal_x_s1;
	assign cal_y     = cal_y_s1;
	assign cal_z     = cal_z_s1;
	assign heading   = heading_s1;

endmodule

`default_nettype wire

@@ src/magnetometer_calibrate_heading.sv @@
// Magnetometer calibration and compass heading.
//
// Input channel (in_valid/in_ready, raw_x/raw_y/raw_z): one raw three-axis sample per
// transfer. Output channel (out_valid/out_ready): calibrated axes cal_x/cal_y/cal_z,
// rounded and saturated to 16 bits, and heading = atan2(y, x) in 1/64 degree, 0..23039,
// taken from the unrounded calibrated x and y. A zero vector gives heading 0.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the offsets
// and scales; cfg_ready is always high and unknown indexes are dropped. Write it only
// while no sample is in flight.
//
// From input transfer to out_valid a sample passes offset subtract, scale multiply,
// round and pre-rotate, one stage per CORDIC micro-rotation, then angle wrap and
// output register. Throughput is one sample per cycle when the receiver does not stall.
// Each stage holds its own valid bit, so bubbles close up; when the receiver stalls,
// the pipeline fills and in_ready falls only once every stage is occupied.
// Reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_calibrate_heading import mch_pkg::*; #(
	parameter int unsigned ANGLE_ITERATIONS = ANGLE_ITER_DEFAULT
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [RAW_W-1:0] raw_x,
	input  wire logic signed [RAW_W-1:0] raw_y,
	input  wire logic signed [RAW_W-1:0] raw_z,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [RAW_W-1:0]      cal_x,
	output logic signed [RAW_W-1:0]      cal_y,
	output logic signed [RAW_W-1:0]      cal_z,
	output logic [HEAD_W-1:0]            heading
);

	// the angle table stops at 24 entries
	localparam int unsigned N_ROT =
		(ANGLE_ITERATIONS < ANGLE_ITER_MAX) ? ANGLE_ITERATIONS : ANGLE_ITER_MAX;

	cfg_t             cfg;
	logic [N_ROT:0]   stage_valid;
	logic [N_ROT:0]   stage_ready;
	vec_t             stage_vec [0:N_ROT];

	mch_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// offset, scale, round and pre-rotate
	mch_calib u_calib (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.raw_x     (raw_x),
		.raw_y     (raw_y),
		.raw_z     (raw_z),
		.out_valid (stage_valid[0]),
		.out_ready (stage_ready[0]),
		.out_vec   (stage_vec[0])
	);

	// one register stage per micro-rotation
	for (genvar g = 0; g < N_ROT; g++) begin : g_rot
		mch_cordic_stage #(
			.STAGE_IDX (g)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_valid[g]),
			.in_ready  (stage_ready[g]),
			.in_vec    (stage_vec[g]),
			.out_valid (stage_valid[g+1]),
			.out_ready (stage_ready[g+1]),
			.out_vec   (stage_vec[g+1])
		);
	end

	// wrap, round and hold the result for the receiver
	mch_heading u_heading (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stage_valid[N_ROT]),
		.in_ready  (stage_ready[N_ROT]),
		.in_vec    (stage_vec[N_ROT]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cal_x     (cal_x),
		.cal_y     (cal_y),
		.cal_z     (cal_z),
		.heading   (heading)
	);

	// a presented heading never reaches a full turn
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading < HEAD_W'(HEADING_FULL)))
		else $error("heading out of range");

	// an empty output register leaves the whole pipeline open
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output stage empty");

	// a receiver taking results must never back-pressure the source
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while receiver ready");

endmodule

`default_nettype wire
